### rtl/hfsm_pkg.sv
// Package: shared types, codes, default sizes and the span merge function of the heightfield span store.
`default_nettype none
package hfsm_pkg;

  localparam int GridWidthDef = 64;
  localparam int GridDepthDef = 64;
  localparam int MaxSpansDef  = 16;

  localparam int SpanW   = 40;
  localparam int StatusW = 2;
  localparam int CountW  = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam logic [StatusW-1:0] STAT_INSERTED = 2'd0;
  localparam logic [StatusW-1:0] STAT_FULL     = 2'd1;
  localparam logic [StatusW-1:0] STAT_READ     = 2'd2;

  typedef struct packed {
    logic [15:0] bot;
    logic [15:0] top;
    logic [7:0]  area;
  } span_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CNT,
    ST_WALK,
    ST_RD_DATA,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_MERGE,
    PH_TAIL
  } phase_e;

  function automatic span_t merge_span(span_t cur, span_t s);
    span_t m;
    m = cur;
    if (cur.top == s.top) begin
      if (s.area > cur.area) m.area = s.area;
    end else if (cur.top < s.top) begin
      m.area = s.area;
    end
    if (s.bot < cur.bot) m.bot = s.bot;
    if (s.top > cur.top) m.top = s.top;
    return m;
  endfunction

endpackage
`default_nettype wire

### rtl/heightfield_span_merge_store.sv
// Top level: heightfield column store with span insert/merge and column read-out.
// Insert: count read, one stored span per cycle over the column, then a write-back of
//   the last span and the new count (none when the column is full).
// Read: count read, then for each span a span RAM read and an output load, which waits for the output.
// Reset: a clearing pass writes every column count to zero, one per cycle, with
//   in_ready_o low until it ends.
`default_nettype none
module heightfield_span_merge_store #(
  parameter int GRID_WIDTH = hfsm_pkg::GridWidthDef,
  parameter int GRID_DEPTH = hfsm_pkg::GridDepthDef,
  parameter int MAX_SPANS  = hfsm_pkg::MaxSpansDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         command_i,
  input  wire logic [5:0]                   column_x_i,
  input  wire logic [5:0]                   column_z_i,
  input  wire logic [15:0]                  span_bottom_i,
  input  wire logic [15:0]                  span_top_i,
  input  wire logic [7:0]                   span_area_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [hfsm_pkg::StatusW-1:0]      status_o,
  output logic [15:0]                       out_bottom_o,
  output logic [15:0]                       out_top_o,
  output logic [7:0]                        out_area_o,
  output logic [hfsm_pkg::CountW-1:0]       span_count_o,
  output logic                              last_o
);
  import hfsm_pkg::*;

  localparam int NCols     = GRID_WIDTH * GRID_DEPTH;
  localparam int ColW      = (NCols > 1) ? $clog2(NCols) : 1;
  localparam int CntW      = $clog2(MAX_SPANS + 1);
  localparam int SpanDepth = NCols * MAX_SPANS;
  localparam int SpanAw    = $clog2(SpanDepth);

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  logic [ColW-1:0]   clr_idx_q, clr_idx_d;
  logic              vld_q, vld_d;
  logic              cmd_q, cmd_d;
  logic [ColW-1:0]   col_q, col_d;
  logic [SpanAw-1:0] base_q, base_d;
  span_t             cur_q, cur_d;
  span_t             pend_q, pend_d;
  logic [CntW-1:0]   c_q, c_d;
  logic [CntW-1:0]   rd_idx_q, rd_idx_d;
  logic [CntW-1:0]   w_q, w_d;

  logic [StatusW-1:0] res_status_q, res_status_d;
  span_t              res_span_q, res_span_d;
  logic [CntW-1:0]    res_cnt_q, res_cnt_d;
  logic               res_last_q, res_last_d;

  logic               out_valid_q, out_valid_d;
  logic [StatusW-1:0] out_status_q, out_status_d;
  span_t              out_span_q, out_span_d;
  logic [CntW-1:0]    out_cnt_q, out_cnt_d;
  logic               out_last_q, out_last_d;
  logic               out_load, out_free;

  logic              cnt_we, cnt_re;
  logic [ColW-1:0]   cnt_waddr, cnt_raddr;
  logic [CntW-1:0]   cnt_wdata, cnt_rdata;
  logic              span_we, span_re;
  logic [SpanAw-1:0] span_waddr, span_raddr;
  logic [SpanW-1:0]  span_wdata, span_rdata;

  logic      in_outside;
  logic [ColW-1:0] in_col;
  span_t     in_span;
  span_t     s;
  span_t     mrg;

  assign in_outside = (32'(column_x_i) >= GRID_WIDTH) || (32'(column_z_i) >= GRID_DEPTH);
  assign in_col     = ColW'(32'(column_z_i) * GRID_WIDTH + 32'(column_x_i));
  assign in_span.bot  = span_bottom_i;
  assign in_span.top  = (span_top_i < span_bottom_i) ? span_bottom_i : span_top_i;
  assign in_span.area = span_area_i;

  assign s   = span_t'(span_rdata);
  assign mrg = merge_span(cur_q, s);

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  hfsm_ram #(.Width(CntW), .Depth(NCols)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  hfsm_ram #(.Width(SpanW), .Depth(SpanDepth)) u_span_ram (
    .clk_i   (clk_i),
    .we_i    (span_we),
    .waddr_i (span_waddr),
    .wdata_i (span_wdata),
    .re_i    (span_re),
    .raddr_i (span_raddr),
    .rdata_o (span_rdata)
  );

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    clr_idx_d    = clr_idx_q;
    vld_d        = vld_q;
    cmd_d        = cmd_q;
    col_d        = col_q;
    base_d       = base_q;
    cur_d        = cur_q;
    pend_d       = pend_q;
    c_d          = c_q;
    rd_idx_d     = rd_idx_q;
    w_d          = w_q;
    res_status_d = res_status_q;
    res_span_d   = res_span_q;
    res_cnt_d    = res_cnt_q;
    res_last_d   = res_last_q;
    out_load     = 1'b0;
    cnt_we       = 1'b0;
    cnt_waddr    = col_q;
    cnt_wdata    = '0;
    cnt_re       = 1'b0;
    cnt_raddr    = in_col;
    span_we      = 1'b0;
    span_waddr   = base_q + SpanAw'(w_q);
    span_wdata   = SpanW'(pend_q);
    span_re      = 1'b0;
    span_raddr   = base_q + SpanAw'(rd_idx_q);

    unique case (state_q)
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_idx_q;
        if (clr_idx_q == ColW'(NCols - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_idx_d = clr_idx_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d  = command_i;
          col_d  = in_col;
          base_d = SpanAw'(32'(in_col) * MAX_SPANS);
          cur_d  = in_span;
          if (in_outside) begin
            res_cnt_d  = '0;
            res_last_d = 1'b1;
            if (command_i == CMD_READ) begin
              res_status_d = STAT_READ;
              res_span_d   = '0;
            end else begin
              res_status_d = STAT_FULL;
              res_span_d   = in_span;
            end
            state_d = ST_EMIT;
          end else begin
            cnt_re  = 1'b1;
            state_d = ST_CNT;
          end
        end
      end
      ST_CNT: begin
        c_d      = cnt_rdata;
        rd_idx_d = '0;
        if (cmd_q == CMD_READ) begin
          if (cnt_rdata == '0) begin
            res_status_d = STAT_READ;
            res_span_d   = '0;
            res_cnt_d    = '0;
            res_last_d   = 1'b1;
            state_d      = ST_EMIT;
          end else begin
            span_re    = 1'b1;
            span_raddr = base_q;
            state_d    = ST_RD_DATA;
          end
        end else begin
          vld_d   = 1'b0;
          phase_d = PH_SKIP;
          w_d     = '0;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (rd_idx_q < c_q) begin
          span_re  = 1'b1;
          rd_idx_d = rd_idx_q + 1'b1;
          vld_d    = 1'b1;
        end else begin
          vld_d = 1'b0;
        end
        if (vld_q) begin
          case (phase_q)
            PH_SKIP: begin
              if (s.top < cur_q.bot) begin
                w_d = w_q + 1'b1;
              end else if (s.bot <= cur_q.top) begin
                cur_d   = mrg;
                phase_d = PH_MERGE;
              end else if (32'(c_q) >= MAX_SPANS) begin
                res_status_d = STAT_FULL;
                res_span_d   = cur_q;
                res_cnt_d    = c_q;
                res_last_d   = 1'b1;
                vld_d        = 1'b0;
                state_d      = ST_EMIT;
              end else begin
                span_we    = 1'b1;
                span_wdata = SpanW'(cur_q);
                pend_d     = s;
                w_d        = w_q + 1'b1;
                phase_d    = PH_TAIL;
              end
            end
            PH_MERGE: begin
              if (s.bot <= cur_q.top) begin
                cur_d = mrg;
              end else begin
                span_we    = 1'b1;
                span_wdata = SpanW'(cur_q);
                pend_d     = s;
                w_d        = w_q + 1'b1;
                phase_d    = PH_TAIL;
              end
            end
            default: begin
              span_we = 1'b1;
              pend_d  = s;
              w_d     = w_q + 1'b1;
            end
          endcase
        end else if (rd_idx_q == c_q) begin
          if (phase_q == PH_SKIP && 32'(c_q) >= MAX_SPANS) begin
            res_status_d = STAT_FULL;
            res_span_d   = cur_q;
            res_cnt_d    = c_q;
          end else begin
            span_we      = 1'b1;
            span_wdata   = (phase_q == PH_TAIL) ? SpanW'(pend_q) : SpanW'(cur_q);
            cnt_we       = 1'b1;
            cnt_wdata    = w_q + 1'b1;
            res_status_d = STAT_INSERTED;
            res_span_d   = cur_q;
            res_cnt_d    = w_q + 1'b1;
          end
          res_last_d = 1'b1;
          state_d    = ST_EMIT;
        end
      end
      ST_RD_DATA: begin
        res_status_d = STAT_READ;
        res_span_d   = s;
        res_cnt_d    = c_q;
        res_last_d   = (32'(rd_idx_q) + 1 == 32'(c_q));
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (res_last_q) begin
            state_d = ST_IDLE;
          end else begin
            span_re    = 1'b1;
            span_raddr = base_q + SpanAw'(rd_idx_q) + 1'b1;
            rd_idx_d   = rd_idx_q + 1'b1;
            state_d    = ST_RD_DATA;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_span_d   = out_span_q;
    out_cnt_d    = out_cnt_q;
    out_last_d   = out_last_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_span_d   = res_span_q;
      out_cnt_d    = res_cnt_q;
      out_last_d   = res_last_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      vld_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q      <= phase_d;
    cmd_q        <= cmd_d;
    col_q        <= col_d;
    base_q       <= base_d;
    cur_q        <= cur_d;
    pend_q       <= pend_d;
    c_q          <= c_d;
    rd_idx_q     <= rd_idx_d;
    w_q          <= w_d;
    res_status_q <= res_status_d;
    res_span_q   <= res_span_d;
    res_cnt_q    <= res_cnt_d;
    res_last_q   <= res_last_d;
    out_status_q <= out_status_d;
    out_span_q   <= out_span_d;
    out_cnt_q    <= out_cnt_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign out_bottom_o = out_span_q.bot;
  assign out_top_o    = out_span_q.top;
  assign out_area_o   = out_span_q.area;
  assign span_count_o = CountW'(out_cnt_q);
  assign last_o       = out_last_q;

endmodule
`default_nettype wire

### rtl/hfsm_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module hfsm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/hfsm_sva.sv
// Port-level checker for the heightfield span store, bound to the top level.
`default_nettype none
module hfsm_sva (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic                         command_i,
  input wire logic [5:0]                   column_x_i,
  input wire logic [5:0]                   column_z_i,
  input wire logic [15:0]                  span_bottom_i,
  input wire logic [15:0]                  span_top_i,
  input wire logic [7:0]                   span_area_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [hfsm_pkg::StatusW-1:0] status_o,
  input wire logic [15:0]                  out_bottom_o,
  input wire logic [15:0]                  out_top_o,
  input wire logic [7:0]                   out_area_o,
  input wire logic [hfsm_pkg::CountW-1:0]  span_count_o,
  input wire logic                         last_o
);
  import hfsm_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output item dropped before accept");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(status_o) && $stable(out_bottom_o)
      && $stable(out_top_o) && $stable(out_area_o) && $stable(span_count_o)
      && $stable(last_o))
    else $error("stalled output item changed");

  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_INSERTED || status_o == STAT_FULL) |-> last_o)
    else $error("insert answered by more than one item");

  a_insert_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_INSERTED |-> span_count_o != '0
      && out_bottom_o <= out_top_o)
    else $error("inserted span left column empty or inverted");

  a_read_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_READ && !last_o |-> span_count_o != '0)
    else $error("read run without stored spans");

endmodule

bind heightfield_span_merge_store hfsm_sva u_hfsm_sva (.*);
`default_nettype wire
